// ===== hw/rtl/pcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfp_pkg
// Shared constants for the print command frame parser: field widths, frame
// flag, input item kinds, result kinds, configuration reset values and indexes.
// ----------------------------------------------------------------------------
package pcfp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Frame start marker
    localparam logic [BYTE_W-1:0] FRAME_FLAG = 8'h1F;

    // Configuration reset values
    localparam logic [WORD_W-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [WORD_W-1:0] MAX_PAYLOAD_RESET = 16'd104;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

    // Input item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LAST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

endpackage

// ===== hw/rtl/print_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// print_command_frame_parser
// Parses a byte stream of length-prefixed command frames, streams payload
// bytes out with their index and reports idle-timeout aborts.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  in       | in_valid, in_ready, req_type, rx_byte          | sink
//  out      | out_valid, out_ready, result_kind, command,    | source
//           | parameter_res, payload_length, payload_byte,   |
//           | payload_index, frame_done                      |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data      | sink
//
//  Each item is captured in an input register and then parsed into the
//  parser state and the result register; one item per cycle is sustained
//  while the result register is empty or being taken.
//  The input stage only holds when the result register is full and not being
//  taken; a new item is accepted while the previous one is parsed.
//  Reset restores flag hunting, clears the held header and counters and loads
//  the configuration reset values. cfg writes are always accepted.
//
module print_command_frame_parser
    import pcfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [BYTE_W-1:0]     rx_byte,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     result_kind,
    output logic [BYTE_W-1:0]     command,
    output logic [WORD_W-1:0]     parameter_res,
    output logic [WORD_W-1:0]     payload_length,
    output logic [BYTE_W-1:0]     payload_byte,
    output logic [WORD_W-1:0]     payload_index,
    output logic                  frame_done,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_CMD,
        PH_PAR_L,
        PH_PAR_H,
        PH_LEN_L,
        PH_LEN_H,
        PH_DATA
    } phase_t;

    // Configuration registers
    logic [WORD_W-1:0] timeout_reg;
    logic [WORD_W-1:0] max_payload_reg;

    // Input stage
    logic              in_valid_reg;
    logic              req_type_reg;
    logic [BYTE_W-1:0] rx_byte_reg;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] held_cmd_reg, held_cmd_next;
    logic [WORD_W-1:0] held_par_reg, held_par_next;
    logic [WORD_W-1:0] held_len_reg, held_len_next;
    logic [WORD_W-1:0] rcvd_reg, rcvd_next;
    logic [WORD_W-1:0] idle_reg, idle_next;

    // Result register
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] res_cmd_reg;
    logic [WORD_W-1:0] res_par_reg;
    logic [WORD_W-1:0] res_len_reg;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [WORD_W-1:0] index_reg, index_next;
    logic              done_reg, done_next;
    logic              emit;

    // Stage handshake
    logic              advance;
    logic [WORD_W-1:0] idle_inc;
    logic [WORD_W:0]   idx_plus1;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            req_type_reg <= REQ_BYTE;
            rx_byte_reg  <= '0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
            if (in_valid)
            begin
                req_type_reg <= req_type;
                rx_byte_reg  <= rx_byte;
            end
        end
    end

    // Parse one item
    assign idle_inc  = (idle_reg == {WORD_W{1'b1}}) ? idle_reg : idle_reg + WORD_W'(1);
    assign idx_plus1 = {1'b0, rcvd_reg} + (WORD_W+1)'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        held_cmd_next = held_cmd_reg;
        held_par_next = held_par_reg;
        held_len_next = held_len_reg;
        rcvd_next     = rcvd_reg;
        idle_next     = idle_reg;
        emit          = 1'b0;
        kind_next     = KIND_DATA;
        data_next     = '0;
        index_next    = '0;
        done_next     = 1'b0;

        if (req_type_reg == REQ_TICK)
        begin
            // Idle counting only inside a frame
            if (phase_reg == PH_FLAG)
            begin
                idle_next = '0;
            end
            else
            begin
                idle_next = idle_inc;
                if (idle_inc >= timeout_reg)
                begin
                    phase_next = PH_FLAG;
                    idle_next  = '0;
                    emit       = 1'b1;
                    kind_next  = KIND_ABORT;
                    index_next = rcvd_reg;
                end
            end
        end
        else
        begin
            idle_next = '0;
            unique case (phase_reg)
                PH_FLAG:
                begin
                    if (rx_byte_reg == FRAME_FLAG)
                        phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    held_cmd_next = rx_byte_reg;
                    phase_next    = PH_PAR_L;
                end
                PH_PAR_L:
                begin
                    held_par_next = {{(WORD_W-BYTE_W){1'b0}}, rx_byte_reg};
                    phase_next    = PH_PAR_H;
                end
                PH_PAR_H:
                begin
                    held_par_next = {rx_byte_reg, held_par_reg[BYTE_W-1:0]};
                    phase_next    = PH_LEN_L;
                end
                PH_LEN_L:
                begin
                    held_len_next = {{(WORD_W-BYTE_W){1'b0}}, rx_byte_reg};
                    phase_next    = PH_LEN_H;
                end
                PH_LEN_H:
                begin
                    held_len_next = {rx_byte_reg, held_len_reg[BYTE_W-1:0]};
                    rcvd_next     = '0;
                    if (held_len_next == '0)
                    begin
                        // Frame without payload completes here
                        phase_next = PH_FLAG;
                        emit       = 1'b1;
                        kind_next  = KIND_EMPTY;
                        done_next  = 1'b1;
                    end
                    else if (held_len_next > max_payload_reg)
                        phase_next = PH_FLAG;
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    rcvd_next  = idx_plus1[WORD_W-1:0];
                    emit       = 1'b1;
                    data_next  = rx_byte_reg;
                    index_next = rcvd_reg;
                    if (idx_plus1 >= {1'b0, held_len_reg})
                    begin
                        phase_next = PH_FLAG;
                        kind_next  = KIND_LAST;
                        done_next  = 1'b1;
                    end
                end
                default:
                begin
                    // Unused code: same as flag hunting
                    phase_next = (rx_byte_reg == FRAME_FLAG) ? PH_CMD : PH_FLAG;
                end
            endcase
        end
    end

    // Parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAG;
            held_cmd_reg  <= '0;
            held_par_reg  <= '0;
            held_len_reg  <= '0;
            rcvd_reg      <= '0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_DATA;
            res_cmd_reg   <= '0;
            res_par_reg   <= '0;
            res_len_reg   <= '0;
            data_reg      <= '0;
            index_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && emit;
            if (in_valid_reg)
            begin
                phase_reg    <= phase_next;
                held_cmd_reg <= held_cmd_next;
                held_par_reg <= held_par_next;
                held_len_reg <= held_len_next;
                rcvd_reg     <= rcvd_next;
                idle_reg     <= idle_next;
                if (emit)
                begin
                    kind_reg    <= kind_next;
                    res_cmd_reg <= held_cmd_next;
                    res_par_reg <= held_par_next;
                    res_len_reg <= held_len_next;
                    data_reg    <= data_next;
                    index_reg   <= index_next;
                    done_reg    <= done_next;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign command        = res_cmd_reg;
    assign parameter_res  = res_par_reg;
    assign payload_length = res_len_reg;
    assign payload_byte   = data_reg;
    assign payload_index  = index_reg;
    assign frame_done     = done_reg;

`ifndef SYNTHESIS
    // Done flag marks exactly the completing kinds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_done == ((result_kind == KIND_LAST) || (result_kind == KIND_EMPTY))))
        else $error("frame_done does not match result kind");

    // Payload count never reaches the declared length while in payload phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (rcvd_reg < held_len_reg))
        else $error("payload count overran declared length");

    // No idle counting while hunting for the flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FLAG) |-> (idle_reg == '0))
        else $error("idle counter nonzero while hunting flag");

    // A completing or aborting result leaves the parser hunting for a flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && emit && (kind_next != KIND_DATA))
        |=> (phase_reg == PH_FLAG))
        else $error("parser not back to flag hunting after frame end");
`endif

endmodule
